/* sv/sidrd_pkg.sv */
`timescale 1ns / 1ps

package sidrd_pkg;

   // Field widths
   localparam int DATA_W     = 8;   // one schedule byte
   localparam int SLOT_W     = 16;  // slot ID
   localparam int INDEX_W    = 6;   // slot position in the frame
   localparam int COUNT_W    = 7;   // slot count / slots emitted
   localparam int DW_FIELD_W = 5;   // raw delta width field of the widths byte
   localparam int DW_W       = 4;   // stored delta width (1..8)
   localparam int LW_W       = 3;   // stored length width (1..7)
   localparam int LEN_W      = 7;   // run length field, up to 2^LW_W - 1
   localparam int DELTA_W    = 8;   // run delta field
   localparam int BITS_W     = 4;   // bits left in the byte shifter (0..8)

   // Limits and reset values
   localparam logic [COUNT_W-1:0]    MAX_SLOTS   = COUNT_W'(64);
   localparam logic [COUNT_W-1:0]    MIN_SLOTS   = COUNT_W'(2);
   localparam logic [COUNT_W-1:0]    COUNT_RESET = COUNT_W'(2);
   localparam logic [DW_FIELD_W-1:0] DW_LIMIT    = DW_FIELD_W'(8);

   // Register port
   localparam int                  CSR_ADDR_W     = 2;
   localparam int                  CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SLOT_COUNT = CSR_ADDR_W'(0);

   // Commands from the sequencer to the bit unpacker
   typedef struct packed {
      logic clear;  // new frame header: empty the run collectors
      logic load;   // take a fresh data byte
      logic step;   // consume one bit
   } unpack_ctl_type;

   // Status from the bit unpacker
   typedef struct packed {
      logic              run_done;   // the bit consumed now completes a run
      logic              final_bit;  // the bit consumed now is the last of the byte
      logic              more;       // bits of the byte remain
      logic [LEN_W-1:0]  run_len;
      logic [DELTA_W-1:0] run_delta;
   } unpack_stat_type;

endpackage

/* sv/sidrd_req_if.sv */
`timescale 1ns / 1ps

interface sidrd_req_if import sidrd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* sv/sidrd_rsp_if.sv */
`timescale 1ns / 1ps

interface sidrd_rsp_if import sidrd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot_value;
   logic [INDEX_W-1:0] slot_index;
   logic               last;
   logic               error;

   modport source (output valid, output slot_value, output slot_index, output last,
                   output error, input ready);
   modport sink   (input valid, input slot_value, input slot_index, input last,
                   input error, output ready);
endinterface

/* sv/sidrd_unpack.sv */
`timescale 1ns / 1ps

// Bit-serial run unpacker: shifts a data byte out LSB first, one bit per
// cycle while step is asserted, and drops each bit into the length or the delta collector.
module sidrd_unpack import sidrd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  unpack_ctl_type      ctl,
   input  logic [DATA_W-1:0]   data_byte,
   input  logic [DW_W-1:0]     delta_width,
   input  logic [LW_W-1:0]     length_width,
   output unpack_stat_type     stat
);

   logic [DATA_W-1:0]  shift_ff, shift_in;
   logic [BITS_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic               in_delta_ff, in_delta_in;
   logic [LW_W-1:0]    cnt_ff, cnt_in;
   logic               cur_bit;
   logic               run_done;

   assign cur_bit = shift_ff[0];

   // next state of shifter and collectors
   always_comb begin
      shift_in    = shift_ff;
      left_in     = left_ff;
      len_in      = len_ff;
      delta_in    = delta_ff;
      in_delta_in = in_delta_ff;
      cnt_in      = cnt_ff;
      run_done    = 1'b0;
      if (ctl.clear) begin
         len_in      = '0;
         delta_in    = '0;
         in_delta_in = 1'b0;
         cnt_in      = '0;
         left_in     = '0;
      end else if (ctl.load) begin
         shift_in = data_byte;
         left_in  = BITS_W'(DATA_W);
      end else if (ctl.step) begin
         shift_in = shift_ff >> 1;
         left_in  = left_ff - BITS_W'(1);
         if (!in_delta_ff) begin
            // length field comes first
            len_in[cnt_ff] = cur_bit;
            if (cnt_ff == length_width - LW_W'(1)) begin
               in_delta_in = 1'b1;
               cnt_in      = '0;
            end else begin
               cnt_in = cnt_ff + LW_W'(1);
            end
         end else begin
            delta_in[cnt_ff] = cur_bit;
            if ({1'b0, cnt_ff} == delta_width - DW_W'(1)) begin
               run_done    = 1'b1;
               in_delta_in = 1'b0;
               cnt_in      = '0;
            end else begin
               cnt_in = cnt_ff + LW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= '0;
         in_delta_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         left_ff     <= left_in;
         in_delta_ff <= in_delta_in;
         cnt_ff      <= cnt_in;
      end
      shift_ff <= shift_in;
      len_ff   <= len_in;
      delta_ff <= delta_in;
   end

   assign stat.run_done  = run_done;
   assign stat.final_bit = (left_ff == BITS_W'(1));
   assign stat.more      = (left_ff != '0);
   assign stat.run_len   = len_ff;
   assign stat.run_delta = delta_ff;

endmodule

/* sv/sorted_id_delta_run_decoder.sv */
`timescale 1ns / 1ps

// Delta-run schedule decoder.
// req_chan carries one frame byte per transaction; frame_start marks byte 0.
// Bytes 0/1 are the first slot ID (low byte first), byte 2 holds the delta
// width (upper 5 bits) and length width (lower 3 bits), later bytes carry
// (length, delta) runs LSB first. rsp_chan returns one transaction per slot:
// value, index, last, error. A bad header gives a single error transaction.
// slot_count (APB register at address 0, reset 2, capped at 64) sets the
// number of slots per frame; write it only while the decoder is idle.
// A run data byte is shifted through a bit-serial unpacker one bit per cycle,
// pausing while the slots of each completed run are emitted. The result
// register holds one transaction; while the receiver stalls, slot generation
// waits, and a new byte is taken only after all slots of the current byte
// have been loaded into it. After reset the decoder is idle and ignores bytes
// until one arrives with frame_start.
module sorted_id_delta_run_decoder import sidrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sidrd_req_if.sink             req_chan,
   sidrd_rsp_if.source           rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [1:0] {S_IDLE, S_HEAD, S_SHIFT, S_EMIT} state_type;
   typedef enum logic [1:0] {PH_ID_LO, PH_ID_HI, PH_WIDTHS, PH_RUNS} phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [DATA_W-1:0]    id_low_ff, id_low_in;
   logic [SLOT_W-1:0]    prev_ff, prev_in;
   logic [COUNT_W-1:0]   emitted_ff, emitted_in;
   logic [DW_W-1:0]      dw_ff, dw_in;
   logic [LW_W-1:0]      lw_ff, lw_in;
   logic                 done_ff, done_in;
   logic                 hdr_err_ff, hdr_err_in;
   logic [LEN_W-1:0]     rep_ff, rep_in;
   logic [COUNT_W-1:0]   slot_count_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_error_ff, rsp_error_in;

   unpack_ctl_type       ctl;
   unpack_stat_type      stat;

   logic [COUNT_W-1:0]    eff_count;
   logic                  req_fire;
   logic                  out_free;
   logic                  out_load;
   logic [DW_FIELD_W-1:0] dw_byte;
   logic [LW_W-1:0]       lw_byte;
   logic                  hdr_bad;
   logic [SLOT_W-1:0]     next_slot;
   logic                  emit_last;
   phase_type             cur_phase;
   logic                  cur_done;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_SLOT_COUNT) ?
                   {(CSR_DATA_W - COUNT_W)'(0), slot_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_SLOT_COUNT)) begin
         slot_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // shared terms
   assign eff_count = (slot_count_ff > MAX_SLOTS) ? MAX_SLOTS : slot_count_ff;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign dw_byte   = req_chan.data_byte[DATA_W-1:LW_W];
   assign lw_byte   = req_chan.data_byte[LW_W-1:0];
   assign hdr_bad   = (dw_byte == '0) || (dw_byte > DW_LIMIT) || (lw_byte == '0) ||
                      (eff_count < MIN_SLOTS);
   assign next_slot = prev_ff + SLOT_W'(stat.run_delta);
   assign emit_last = ((emitted_ff + COUNT_W'(1)) >= eff_count);
   assign cur_phase = req_chan.frame_start ? PH_ID_LO : phase_ff;
   assign cur_done  = req_chan.frame_start ? 1'b0 : done_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      id_low_in    = id_low_ff;
      prev_in      = prev_ff;
      emitted_in   = emitted_ff;
      dw_in        = dw_ff;
      lw_in        = lw_ff;
      done_in      = done_ff;
      hdr_err_in   = hdr_err_ff;
      rep_in       = rep_ff;
      ctl          = '0;
      out_load     = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.frame_start) begin
                  phase_in   = PH_ID_LO;
                  done_in    = 1'b0;
                  id_low_in  = '0;
                  prev_in    = '0;
                  emitted_in = '0;
                  dw_in      = '0;
                  lw_in      = '0;
               end
               if (!cur_done) begin
                  unique case (cur_phase)
                     PH_ID_LO: begin
                        id_low_in = req_chan.data_byte;
                        phase_in  = PH_ID_HI;
                     end
                     PH_ID_HI: begin
                        prev_in  = {req_chan.data_byte, id_low_ff};
                        phase_in = PH_WIDTHS;
                     end
                     PH_WIDTHS: begin
                        hdr_err_in = hdr_bad;
                        state_in   = S_HEAD;
                        if (hdr_bad) begin
                           done_in = 1'b1;
                        end else begin
                           dw_in      = dw_byte[DW_W-1:0];
                           lw_in      = lw_byte;
                           emitted_in = COUNT_W'(1);
                           phase_in   = PH_RUNS;
                           ctl.clear  = 1'b1;
                        end
                     end
                     PH_RUNS: begin
                        // count lowered below what was sent: close the frame quietly
                        if (emitted_ff >= eff_count) begin
                           done_in = 1'b1;
                        end else begin
                           ctl.load = 1'b1;
                           state_in = S_SHIFT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_HEAD: begin
            // first slot or error transaction
            if (out_free) begin
               out_load     = 1'b1;
               rsp_value_in = hdr_err_ff ? '0 : prev_ff;
               rsp_index_in = '0;
               rsp_last_in  = hdr_err_ff;
               rsp_error_in = hdr_err_ff;
               state_in     = S_IDLE;
            end
         end
         S_SHIFT: begin
            ctl.step = 1'b1;
            if (stat.run_done) begin
               rep_in   = '0;
               state_in = S_EMIT;
            end else if (stat.final_bit) begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // one slot per cycle while the result register is free
            if (out_free) begin
               out_load     = 1'b1;
               rsp_value_in = next_slot;
               rsp_index_in = emitted_ff[INDEX_W-1:0];
               rsp_last_in  = emit_last;
               rsp_error_in = 1'b0;
               prev_in      = next_slot;
               emitted_in   = emitted_ff + COUNT_W'(1);
               if (emit_last) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else if (rep_ff == stat.run_len) begin
                  state_in = stat.more ? S_SHIFT : S_IDLE;
               end else begin
                  rep_in = rep_ff + LEN_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ID_LO;
         id_low_ff    <= '0;
         prev_ff      <= '0;
         emitted_ff   <= '0;
         dw_ff        <= '0;
         lw_ff        <= '0;
         done_ff      <= 1'b1;
         hdr_err_ff   <= 1'b0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         id_low_ff    <= id_low_in;
         prev_ff      <= prev_in;
         emitted_ff   <= emitted_in;
         dw_ff        <= dw_in;
         lw_ff        <= lw_in;
         done_ff      <= done_in;
         hdr_err_ff   <= hdr_err_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   // bit-serial run unpacker
   sidrd_unpack u_unpack (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .data_byte    (req_chan.data_byte),
      .delta_width  (dw_ff),
      .length_width (lw_ff),
      .stat         (stat)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.slot_value = rsp_value_ff;
   assign rsp_chan.slot_index = rsp_index_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.error      = rsp_error_ff;

   // checks
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (emitted_ff < eff_count))
      else $error("slot emission past the frame's slot count");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> done_ff)
      else $error("frame still open after its last transaction");

   a_idle_bytes_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_fire && done_ff && !req_chan.frame_start) |=>
      ($stable(emitted_ff) && (state_ff == S_IDLE) && !$rose(rsp_valid_ff)))
      else $error("byte outside a frame changed decoder state");

endmodule

/* verif/sorted_id_delta_run_decoder_test.sv */
`timescale 1ns / 1ps

module sorted_id_delta_run_decoder_test;
   import sidrd_pkg::*;

   localparam int RANDOM_ITEMS = 330;
   localparam int DRAIN_CYCLES = 24;    // lets the unpacker finish its last byte, with margin
   localparam int STALL_CYCLES = 400;

   typedef enum logic [1:0] {WAIT_ID_LO, WAIT_ID_HI, WAIT_WIDTHS, RUN_DATA} sched_phase_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              start;
   } frame_byte_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      logic               last;
      logic               error;
   } slot_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sidrd_req_if req_chan ();
   sidrd_rsp_if rsp_chan ();

   sorted_id_delta_run_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // stimulus and scoreboard bookkeeping
   frame_byte_type pending_bytes[$];
   frame_byte_type next_byte;
   slot_rec_type   expected_slots[$];
   slot_rec_type   want_slot;
   int unsigned queued_total   = 0;
   int unsigned accepted_total = 0;
   int unsigned random_items   = 0;
   bit          counting_items = 1'b0;
   bit          req_fired      = 1'b0;
   int unsigned send_idle_pct  = 36;
   int unsigned recv_idle_pct  = 51;
   int          rsp_hold_left  = 0;
   int          mismatch_count = 0;

   // decoder copy: configuration and frame state
   logic [COUNT_W-1:0] slot_count_reg = COUNT_RESET;
   sched_phase_type    sched_phase    = WAIT_ID_LO;
   logic [7:0]         id_low         = '0;
   logic [SLOT_W-1:0]  last_slot      = '0;
   logic [COUNT_W-1:0] slots_out      = '0;
   logic [21:0]        bit_pool       = '0;
   logic [4:0]         pool_bits      = '0;
   logic [3:0]         delta_bits     = '0;
   logic [2:0]         len_bits       = '0;
   logic               frame_idle     = 1'b1;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Works out the slots that one schedule byte produces
   task automatic decode_byte(input logic [7:0] b, input logic start);
      logic [COUNT_W-1:0]    limit;
      logic [DW_FIELD_W-1:0] dfield;
      int unsigned           group_width;
      int unsigned           run_word;
      int unsigned           run_len;
      int unsigned           run_delta;
      int unsigned           k;
      slot_rec_type          rec;
      limit = (slot_count_reg > MAX_SLOTS) ? MAX_SLOTS : slot_count_reg;
      if (start) begin
         sched_phase = WAIT_ID_LO;
         id_low      = '0;
         last_slot   = '0;
         slots_out   = '0;
         bit_pool    = '0;
         pool_bits   = '0;
         delta_bits  = '0;
         len_bits    = '0;
         frame_idle  = 1'b0;
      end
      if (frame_idle) return;
      case (sched_phase)
         WAIT_ID_LO: begin
            id_low      = b;
            sched_phase = WAIT_ID_HI;
         end
         WAIT_ID_HI: begin
            last_slot   = {b, id_low};
            sched_phase = WAIT_WIDTHS;
         end
         WAIT_WIDTHS: begin
            dfield = b[7:3];
            if (dfield == 0 || dfield > DW_LIMIT || b[2:0] == 3'd0 || limit < MIN_SLOTS) begin
               rec = '{value: '0, index: '0, last: 1'b1, error: 1'b1};
               expected_slots.push_back(rec);
               frame_idle = 1'b1;
            end else begin
               delta_bits = dfield[3:0];
               len_bits   = b[2:0];
               rec = '{value: last_slot, index: '0, last: 1'b0, error: 1'b0};
               expected_slots.push_back(rec);
               slots_out   = COUNT_W'(1);
               bit_pool    = '0;
               pool_bits   = '0;
               sched_phase = RUN_DATA;
            end
         end
         RUN_DATA: begin
            // count may have been lowered under the slots already sent
            if (slots_out >= limit) begin
               frame_idle = 1'b1;
            end else begin
               group_width = delta_bits + len_bits;
               bit_pool    = bit_pool | (22'(b) << pool_bits);
               pool_bits   = pool_bits + 5'd8;
               while (pool_bits >= group_width && !frame_idle) begin
                  run_word  = bit_pool & ((32'd1 << group_width) - 1);
                  run_len   = run_word & ((32'd1 << len_bits) - 1);
                  run_delta = run_word >> len_bits;
                  bit_pool  = bit_pool >> group_width;
                  pool_bits = pool_bits - 5'(group_width);
                  k = 0;
                  while (k <= run_len && !frame_idle) begin
                     last_slot = last_slot + run_delta[SLOT_W-1:0];
                     rec.value = last_slot;
                     rec.index = slots_out[INDEX_W-1:0];
                     rec.last  = (int'(slots_out) + 1 >= int'(limit));
                     rec.error = 1'b0;
                     expected_slots.push_back(rec);
                     slots_out = slots_out + 1'b1;
                     if (rec.last) frame_idle = 1'b1;
                     k++;
                  end
               end
            end
         end
      endcase
   endtask

   // Driver: next byte goes out after the previous transaction or an idle cycle
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_byte = pending_bytes.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.data_byte   <= next_byte.data;
            req_chan.frame_start <= next_byte.start;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Input monitor: every accepted byte feeds the decoder copy
   always @(posedge clock) begin
      req_fired = !reset && req_chan.valid && req_chan.ready;
      if (req_fired) begin
         decode_byte(req_chan.data_byte, req_chan.frame_start);
         accepted_total++;
      end
   end

   // Receiver: random back-pressure, or a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result monitor: compare against the oldest expected slot
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_slots.size() == 0) begin
            report_mismatch($sformatf("unexpected slot value %h index %0d last %b error %b",
                                      rsp_chan.slot_value, rsp_chan.slot_index,
                                      rsp_chan.last, rsp_chan.error));
         end else begin
            want_slot = expected_slots.pop_front();
            if (rsp_chan.slot_value !== want_slot.value)
               report_mismatch($sformatf("slot_value %h, expected %h",
                                         rsp_chan.slot_value, want_slot.value));
            if (rsp_chan.slot_index !== want_slot.index)
               report_mismatch($sformatf("slot_index %0d, expected %0d",
                                         rsp_chan.slot_index, want_slot.index));
            if (rsp_chan.last !== want_slot.last)
               report_mismatch($sformatf("last %b, expected %b (index %0d)",
                                         rsp_chan.last, want_slot.last, want_slot.index));
            if (rsp_chan.error !== want_slot.error)
               report_mismatch($sformatf("error %b, expected %b",
                                         rsp_chan.error, want_slot.error));
         end
      end
   end

   task automatic queue_byte(input logic [7:0] data, input logic start, input bit counted = 1'b1);
      frame_byte_type fb;
      fb.data  = data;
      fb.start = start;
      pending_bytes.push_back(fb);
      queued_total++;
      if (counting_items && counted) random_items++;
   endtask

   // Sender pause: every byte taken and every slot returned, then the unpacker tail
   task automatic wait_drained();
      while (!(accepted_total == queued_total && expected_slots.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write with random upper bits, then a read back
   task automatic write_slot_count(input logic [COUNT_W-1:0] v);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[COUNT_W-1:0] = v;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_SLOT_COUNT;
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      slot_count_reg = v;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== CSR_DATA_W'(v))
         report_mismatch($sformatf("slot_count reads %h, expected %h", prdata, v));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [COUNT_W-1:0] pick_slot_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return COUNT_W'($urandom_range(1));
      if (r < 16) return MAX_SLOTS;
      if (r < 22) return COUNT_W'($urandom_range(127, 65));
      if (r < 26) return COUNT_W'(127);
      return COUNT_W'($urandom_range(12, 2));
   endfunction

   // Well-formed frame: runs packed LSB first until the slot count is covered
   task automatic push_good_frame();
      logic [4:0]  dw;
      logic [2:0]  lw;
      int unsigned target;
      int unsigned produced;
      int unsigned pack;
      int unsigned pack_bits;
      int unsigned run_len;
      int unsigned run_delta;
      dw = 5'($urandom_range(8, 1));
      lw = 3'($urandom_range(7, 1));
      target = (slot_count_reg > MAX_SLOTS) ? MAX_SLOTS : slot_count_reg;
      if (target < 2) target = 2;
      queue_byte(8'($urandom), 1'b1);
      queue_byte(8'($urandom), 1'b0);
      queue_byte({dw, lw}, 1'b0);
      produced  = 1;
      pack      = 0;
      pack_bits = 0;
      while (produced < target) begin
         // short runs mostly, so a frame spans several bytes
         if ($urandom_range(1)) run_len = $urandom_range((1 << lw) - 1);
         else run_len = $urandom_range(1);
         run_delta = $urandom_range((1 << dw) - 1);
         pack = pack | (((run_delta << lw) | run_len) << pack_bits);
         pack_bits += dw + lw;
         produced  += run_len + 1;
         while (pack_bits >= 8) begin
            queue_byte(pack[7:0], 1'b0);
            pack = pack >> 8;
            pack_bits -= 8;
         end
      end
      // trailing bits are random filler
      if (pack_bits > 0) queue_byte(8'(pack | ($urandom << pack_bits)), 1'b0);
      if ($urandom_range(3) == 0) queue_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic push_bad_header();
      logic [7:0] widths;
      widths = 8'($urandom);
      case ($urandom_range(2))
         0: widths[7:3] = 5'd0;
         1: widths[7:3] = 5'($urandom_range(31, 9));
         default: widths[2:0] = 3'd0;
      endcase
      queue_byte(8'($urandom), 1'b1);
      queue_byte(8'($urandom), 1'b0);
      queue_byte(widths, 1'b0);
      if ($urandom_range(1)) queue_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   // Frame cut short; the next frame start abandons it
   task automatic push_cut_frame();
      int unsigned n;
      n = $urandom_range(5, 1);
      queue_byte(8'($urandom), 1'b1);
      for (int i = 1; i < n; i++) begin
         if (i == 2) queue_byte({5'($urandom_range(8, 1)), 3'($urandom_range(7, 1))}, 1'b0);
         else queue_byte(8'($urandom), 1'b0);
      end
   endtask

   initial begin
      bit          pressure_done;
      int unsigned kind;
      pressure_done        = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      req_chan.frame_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // byte while idle after reset: ignored
      queue_byte(8'hA5, 1'b0);
      // widest fields, first ID at the top of the range, next slot wraps to zero
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte({5'd8, 3'd7}, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // bad headers: zero delta width, delta width too wide, zero length width
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte({5'd0, 3'd1}, 1'b0);
      queue_byte(8'h12, 1'b1);
      queue_byte(8'h34, 1'b0);
      queue_byte({5'd9, 3'd1}, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte({5'd31, 3'd0}, 1'b0);
      wait_drained();
      // slot count below the minimum
      write_slot_count(COUNT_W'(0));
      queue_byte(8'h01, 1'b1);
      queue_byte(8'h02, 1'b0);
      queue_byte({5'd1, 3'd1}, 1'b0);
      wait_drained();
      // one-bit fields, all four run patterns in one byte
      write_slot_count(COUNT_W'(40));
      queue_byte(8'h34, 1'b1);
      queue_byte(8'h12, 1'b0);
      queue_byte({5'd1, 3'd1}, 1'b0);
      queue_byte(8'hE4, 1'b0);
      wait_drained();
      // count lowered under the slots already sent: frame ends quietly
      write_slot_count(COUNT_W'(3));
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b0);
      wait_drained();

      counting_items = 1'b1;
      write_slot_count(COUNT_W'(127));
      while (random_items < RANDOM_ITEMS) begin
         while (pending_bytes.size() > 8) @(posedge clock);
         if (random_items < RANDOM_ITEMS / 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 51;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (!pressure_done && random_items >= RANDOM_ITEMS / 2) begin
            // long receiver hold-off while full frames keep coming
            wait_drained();
            write_slot_count(MAX_SLOTS);
            @(posedge clock);
            rsp_hold_left = STALL_CYCLES;
            push_good_frame();
            push_good_frame();
            pressure_done = 1'b1;
         end else begin
            if ($urandom_range(3) == 0) begin
               wait_drained();
               write_slot_count(pick_slot_count());
            end
            kind = $urandom_range(99);
            if (kind < 70) push_good_frame();
            else if (kind < 80) push_bad_header();
            else if (kind < 90) push_cut_frame();
            else repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 1'b0, 1'b0);
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(6_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

/* sorted_id_delta_run_decoder.f */
sv/sidrd_pkg.sv
sv/sidrd_req_if.sv
sv/sidrd_rsp_if.sv
sv/sidrd_unpack.sv
sv/sorted_id_delta_run_decoder.sv
verif/sorted_id_delta_run_decoder_test.sv
